// ===== src/slab_free_list_allocator_assert.svh =====
// Assertion macros for the slot pool allocator.
// Used by the top level, which supplies clk and rst in scope.
`ifndef SLAB_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SLAB_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SFLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sfla_pkg.sv =====
// Shared types and constants for the slot pool allocator.
// No dependencies; imported by sfla_cfg, sfla_core and the top level.
`default_nettype none

package sfla_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int BYTES_W   = 13;
  localparam int OFFS_W    = 20;
  localparam int MIN_BYTES = 8;
  localparam int MAX_BYTES = 4096;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  given_slot;
    logic [OFFS_W-1:0]  byte_offset;
    status_t            status;
    logic [COUNT_W-1:0] available_count;
  } rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] slot_count;
    logic [BYTES_W-1:0] slot_bytes;
    logic               rebuild;
    logic [COUNT_W-1:0] rebuild_count;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/sfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free-list links.
`default_nettype none

module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sfla_cfg.sv =====
// APB register file: slot_count and slot_bytes with range clamping.
// Depends on sfla_pkg; signals a list rebuild on every write.
`default_nettype none

module sfla_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfla_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sfla_pkg::DATA_W-1:0]  pwdata,
  output logic      [sfla_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output sfla_pkg::cfg_t                    cfg
);

  import sfla_pkg::*;

  logic               wr;
  logic               idx;
  logic [COUNT_W-1:0] slot_count;
  logic [BYTES_W-1:0] slot_bytes;
  logic [COUNT_W-1:0] count_in;
  logic [BYTES_W-1:0] bytes_in;
  logic [COUNT_W-1:0] count_clamp;
  logic [BYTES_W-1:0] bytes_clamp;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign idx      = paddr[2];
  assign count_in = pwdata[COUNT_W-1:0];
  assign bytes_in = pwdata[BYTES_W-1:0];

  always_comb begin
    if (count_in == '0) begin
      count_clamp = COUNT_W'(1);
    end else if (count_in > COUNT_W'(MAX_SLOTS)) begin
      count_clamp = COUNT_W'(MAX_SLOTS);
    end else begin
      count_clamp = count_in;
    end
    if (bytes_in < BYTES_W'(MIN_BYTES)) begin
      bytes_clamp = BYTES_W'(MIN_BYTES);
    end else if (bytes_in > BYTES_W'(MAX_BYTES)) begin
      bytes_clamp = BYTES_W'(MAX_BYTES);
    end else begin
      bytes_clamp = bytes_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= COUNT_W'(MAX_SLOTS);
      slot_bytes <= BYTES_W'(MIN_BYTES);
    end else if (wr) begin
      if (idx == REG_SLOT_COUNT) begin
        slot_count <= count_clamp;
      end else begin
        slot_bytes <= bytes_clamp;
      end
    end
  end

  always_comb begin
    cfg.slot_count    = slot_count;
    cfg.slot_bytes    = slot_bytes;
    cfg.rebuild       = wr;
    cfg.rebuild_count = (wr && idx == REG_SLOT_COUNT) ? count_clamp : slot_count;
  end

  assign prdata = (idx == REG_SLOT_COUNT) ? DATA_W'(slot_count) : DATA_W'(slot_bytes);

endmodule

`default_nettype wire

// ===== src/sfla_core.sv =====
// Free-list state, link RAM and the single-pass allocate/free logic.
// Depends on sfla_pkg and sfla_ram; state advances when go is high and is reset on a rebuild.
`default_nettype none

module sfla_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sfla_pkg::cfg_t cfg,
  input  wire logic           go,
  input  wire sfla_pkg::req_t req,
  output sfla_pkg::rsp_t      rsp_next
);

  import sfla_pkg::*;

  logic [SLOT_W-1:0]         head_slot;
  logic [SLOT_W-1:0]         head_link;
  logic                      link_pend;
  logic [COUNT_W-1:0]        high_water;
  logic [COUNT_W-1:0]        free_total;
  logic [COUNT_W-1:0]        free_total_next;
  logic [SLOT_W-1:0]         ram_rdata;
  logic [SLOT_W-1:0]         link_cur;
  logic [COUNT_W-1:0]        untouched;
  logic                      has_linked;
  logic                      bad_free;
  logic                      pop;
  logic                      take_hw;
  logic                      push;
  logic [SLOT_W-1:0]         given;
  status_t                   status;
  logic [SLOT_W+BYTES_W-1:0] prod;

  assign link_cur   = link_pend ? ram_rdata : head_link;
  assign untouched  = cfg.slot_count - high_water;
  assign has_linked = free_total > untouched;
  assign bad_free   = ({1'b0, req.slot} >= cfg.slot_count) ||
                      ({1'b0, req.slot} >= high_water) ||
                      (free_total >= cfg.slot_count);

  always_comb begin
    pop     = 1'b0;
    take_hw = 1'b0;
    push    = 1'b0;
    given   = '0;
    status  = ST_OK;
    if (req.func == FUNC_ALLOC) begin
      if (free_total == '0) begin
        status = ST_NOSPACE;
      end else if (has_linked) begin
        pop   = 1'b1;
        given = head_slot;
      end else begin
        take_hw = 1'b1;
        given   = high_water[SLOT_W-1:0];
      end
    end else begin
      if (bad_free) begin
        status = ST_BADFREE;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_comb begin
    if (pop || take_hw) begin
      free_total_next = free_total - COUNT_W'(1);
    end else if (push) begin
      free_total_next = free_total + COUNT_W'(1);
    end else begin
      free_total_next = free_total;
    end
  end

  assign prod = {{BYTES_W{1'b0}}, given} * {{SLOT_W{1'b0}}, cfg.slot_bytes};

  always_comb begin
    rsp_next.given_slot      = given;
    rsp_next.byte_offset     = prod[OFFS_W-1:0];
    rsp_next.status          = status;
    rsp_next.available_count = free_total_next;
  end

  sfla_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_SLOTS)
  ) u_link_ram (
    .clk  (clk),
    .we   (go && push),
    .waddr(req.slot),
    .wdata(head_slot),
    .re   (go && pop),
    .raddr(link_cur),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot  <= '0;
      high_water <= '0;
      free_total <= COUNT_W'(MAX_SLOTS);
      link_pend  <= 1'b0;
    end else if (cfg.rebuild) begin
      head_slot  <= '0;
      high_water <= '0;
      free_total <= cfg.rebuild_count;
      link_pend  <= 1'b0;
    end else if (go) begin
      free_total <= free_total_next;
      if (pop) begin
        head_slot <= link_cur;
        link_pend <= 1'b1;
      end
      if (take_hw) begin
        high_water <= high_water + COUNT_W'(1);
      end
      if (push) begin
        head_slot <= req.slot;
        link_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && push) begin
      head_link <= head_slot;
    end
  end

endmodule

`default_nettype wire

// ===== src/slab_free_list_allocator.sv =====
// Slot pool allocator: one allocate or free per cycle; a request beat passes through the
// input register, then the result register, before its result appears. The link of the
// head slot is kept in a register or taken from the 256 x 8 link RAM read issued
// by the previous pop, so back-to-back pops never wait on the RAM. A write to
// either register rebuilds the list in the same cycle; there is no clearing pass.
// Throughput is one beat per cycle whenever the result side is not stalled.
// Top level; depends on sfla_pkg, sfla_cfg, sfla_core and the assertion header.
`default_nettype none
`include "slab_free_list_allocator_assert.svh"

module slab_free_list_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire sfla_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output sfla_pkg::rsp_t                   rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sfla_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sfla_pkg::DATA_W-1:0] pwdata,
  output logic      [sfla_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  import sfla_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  req_t s1_req;
  logic go;
  rsp_t rsp_next;

  assign go        = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !go;

  sfla_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  sfla_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .go      (go),
    .req     (s1_req),
    .rsp_next(rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (!req_stall) begin
        s1_valid <= req_valid;
      end
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_req <= req;
    end
    if (go) begin
      rsp <= rsp_next;
    end
  end

  `SFLA_ASSERT_IMP(a_fail_no_slot, rsp_valid && rsp.status != ST_OK, rsp.given_slot == '0 && rsp.byte_offset == '0, "failed beat carries a slot")
  `SFLA_ASSERT_IMP(a_nospace_empty, rsp_valid && rsp.status == ST_NOSPACE, rsp.available_count == '0, "out of space with free slots left")
  `SFLA_ASSERT_NXT(a_go_fills_rsp, go, rsp_valid, "advanced beat did not reach the result register")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for slab_free_list_allocator: a directed table, then random phases that
// reprogram the pool and run alloc/free traffic, checked beat by beat against a predictor.
// Depends on sfla_pkg and the slab_free_list_allocator RTL.
`default_nettype none

module tb;
  import sfla_pkg::*;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    req_t        op;
    logic        sel;
    int unsigned value;
    bit          typed;
    rsp_t        want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  rsp_t                rsp;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // pool predictor state
  int unsigned pool_count = MAX_SLOTS;
  int unsigned pool_bytes = MIN_BYTES;
  int unsigned pool_head = 0;
  int unsigned pool_hw = 0;
  int unsigned pool_free = MAX_SLOTS;
  int unsigned pool_link [MAX_SLOTS];
  int unsigned slots_in_use [$];

  rsp_t        pending_results [$];
  plan_row_t   plan [$];
  int          mismatch_count = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold = 0;

  slab_free_list_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void pool_configure(logic sel, int unsigned v);
    if (sel == REG_SLOT_COUNT) begin
      v = v & 32'h1FF;
      if (v < 1) v = 1;
      if (v > MAX_SLOTS) v = MAX_SLOTS;
      pool_count = v;
    end else begin
      v = v & 32'h1FFF;
      if (v < MIN_BYTES) v = MIN_BYTES;
      if (v > MAX_BYTES) v = MAX_BYTES;
      pool_bytes = v;
    end
    pool_head = 0;
    pool_hw = 0;
    pool_free = pool_count;
    slots_in_use.delete();
  endfunction

  function automatic rsp_t pool_result(req_t r);
    rsp_t        o;
    int unsigned untouched;
    int unsigned linked;
    int unsigned given;
    int          hit;
    o = '0;
    o.status = ST_OK;
    hit = -1;
    if (r.func == FUNC_ALLOC) begin
      if (pool_free == 0) begin
        o.status = ST_NOSPACE;
      end else begin
        untouched = (pool_count > pool_hw) ? pool_count - pool_hw : 0;
        linked = (pool_free > untouched) ? pool_free - untouched : 0;
        if (linked > 0) begin
          given = pool_head;
          pool_head = pool_link[pool_head];
        end else begin
          given = pool_hw;
          pool_hw = pool_hw + 1;
        end
        pool_free = pool_free - 1;
        o.given_slot = given[SLOT_W-1:0];
        o.byte_offset = OFFS_W'(given * pool_bytes);
        slots_in_use.push_back(given);
      end
    end else begin
      if (r.slot >= pool_count || r.slot >= pool_hw || pool_free >= pool_count) begin
        o.status = ST_BADFREE;
      end else begin
        pool_link[r.slot] = pool_head;
        pool_head = r.slot;
        pool_free = pool_free + 1;
        for (int i = 0; i < slots_in_use.size(); i++) begin
          if (hit < 0 && slots_in_use[i] == r.slot) hit = i;
        end
        if (hit >= 0) slots_in_use.delete(hit);
      end
    end
    o.available_count = pool_free[COUNT_W-1:0];
    return o;
  endfunction

  function automatic rsp_t mk_rsp(int unsigned given, int unsigned offs, status_t st,
                                  int unsigned avail);
    rsp_t o;
    o.given_slot = given[SLOT_W-1:0];
    o.byte_offset = offs[OFFS_W-1:0];
    o.status = st;
    o.available_count = avail[COUNT_W-1:0];
    return o;
  endfunction

  function automatic void add_op(logic func, int unsigned slot);
    plan_row_t row;
    row = '{ROW_OP, '0, 1'b0, 0, 1'b0, '0};
    row.op.func = func;
    row.op.slot = slot[SLOT_W-1:0];
    plan.push_back(row);
  endfunction

  function automatic void add_typed(logic func, int unsigned slot, rsp_t want);
    add_op(func, slot);
    plan[$].typed = 1'b1;
    plan[$].want = want;
  endfunction

  function automatic void add_cfg(logic sel, int unsigned value);
    plan_row_t row;
    row = '{ROW_CFG, '0, sel, value, 1'b0, '0};
    plan.push_back(row);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch("result beat with nothing outstanding");
    end else begin
      want = pending_results.pop_front();
      if (got.given_slot !== want.given_slot)
        flag_mismatch($sformatf("given_slot %0d, want %0d", got.given_slot, want.given_slot));
      if (got.byte_offset !== want.byte_offset)
        flag_mismatch($sformatf("byte_offset %0d, want %0d", got.byte_offset,
                                want.byte_offset));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.available_count !== want.available_count)
        flag_mismatch($sformatf("available_count %0d, want %0d", got.available_count,
                                want.available_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        check_result(rsp);
        rx_hold = rx_burst ? 0 : $urandom_range(0, 10);
      end else if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
      end
      rsp_stall <= (rx_hold != 0);
    end
  end

  task automatic send_req(req_t r, bit typed, rsp_t want);
    int unsigned gap;
    rsp_t        predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = pool_result(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    pool_configure(sel, v);
  endtask

  initial begin
    req_t        r;
    int unsigned sent;
    int unsigned items;
    int unsigned alloc_pct;
    int unsigned cnt_val;
    int unsigned byte_val;
    int          phase;

    foreach (pool_link[i]) pool_link[i] = 0;

    add_typed(FUNC_FREE, 0, mk_rsp(0, 0, ST_BADFREE, 256));
    add_typed(FUNC_ALLOC, 255, mk_rsp(0, 0, ST_OK, 255));
    add_typed(FUNC_ALLOC, 0, mk_rsp(1, 8, ST_OK, 254));
    add_typed(FUNC_FREE, 200, mk_rsp(0, 0, ST_BADFREE, 254));
    add_typed(FUNC_FREE, 1, mk_rsp(0, 0, ST_OK, 255));
    add_typed(FUNC_FREE, 0, mk_rsp(0, 0, ST_OK, 256));
    add_typed(FUNC_FREE, 0, mk_rsp(0, 0, ST_BADFREE, 256));
    add_op(FUNC_ALLOC, 0);
    add_op(FUNC_ALLOC, 0);
    add_op(FUNC_ALLOC, 0);
    add_op(FUNC_FREE, 1);
    add_op(FUNC_FREE, 1);
    add_op(FUNC_ALLOC, 0);
    add_op(FUNC_ALLOC, 0);
    add_cfg(REG_SLOT_COUNT, 0);
    add_cfg(REG_SLOT_BYTES, 8191);
    add_typed(FUNC_ALLOC, 0, mk_rsp(0, 0, ST_OK, 0));
    add_typed(FUNC_ALLOC, 170, mk_rsp(0, 0, ST_NOSPACE, 0));
    add_typed(FUNC_FREE, 0, mk_rsp(0, 0, ST_OK, 1));
    add_typed(FUNC_FREE, 0, mk_rsp(0, 0, ST_BADFREE, 1));
    add_cfg(REG_SLOT_COUNT, 2);
    add_typed(FUNC_ALLOC, 0, mk_rsp(0, 0, ST_OK, 1));
    add_typed(FUNC_ALLOC, 0, mk_rsp(1, 4096, ST_OK, 0));
    add_typed(FUNC_FREE, 2, mk_rsp(0, 0, ST_BADFREE, 0));
    add_op(FUNC_FREE, 1);
    add_op(FUNC_FREE, 1);
    add_cfg(REG_SLOT_BYTES, 0);
    add_cfg(REG_SLOT_COUNT, 511);
    add_typed(FUNC_ALLOC, 0, mk_rsp(0, 0, ST_OK, 255));
    add_typed(FUNC_ALLOC, 0, mk_rsp(1, 8, ST_OK, 254));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        send_req(plan[i].op, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 2000) begin
      drain();
      if (phase == 0) begin
        cnt_val = 256;
        byte_val = 4096;
        alloc_pct = 95;
        items = 320;
      end else begin
        case ($urandom_range(0, 5))
          0: cnt_val = 1;
          1: cnt_val = 2;
          2: cnt_val = 256;
          3: cnt_val = $urandom_range(0, 511);
          default: cnt_val = $urandom_range(1, 32);
        endcase
        case ($urandom_range(0, 3))
          0: byte_val = 8;
          1: byte_val = 4096;
          2: byte_val = $urandom_range(0, 8191);
          default: byte_val = $urandom_range(8, 4096);
        endcase
        alloc_pct = $urandom_range(30, 85);
        items = $urandom_range(40, 200);
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SLOT_COUNT, cnt_val);
        write_reg(REG_SLOT_BYTES, byte_val);
      end else begin
        write_reg(REG_SLOT_BYTES, byte_val);
        write_reg(REG_SLOT_COUNT, cnt_val);
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat (items) begin
        r.slot = $urandom_range(0, 255);
        r.func = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        if (r.func == FUNC_FREE && slots_in_use.size() != 0 && $urandom_range(0, 9) < 8)
          r.slot = slots_in_use[$urandom_range(0, slots_in_use.size() - 1)];
        send_req(r, 1'b0, '0);
      end
      sent = sent + items;
      phase++;
    end

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
